@@ design/lpm_pkg.sv @@
`timescale 1ns / 1ps
// types and constants shared by the route lookup block
package lpm_pkg;

	localparam int IDX_W    = 5;
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 4;
	localparam int METRIC_W = 5;

	localparam int PORT_COUNT = 16;

	localparam logic [METRIC_W-1:0] METRIC_INF = 5'd16;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] prefix_mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
		logic [METRIC_W-1:0] route_metric;
		logic              entry_valid;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [IDX_W-1:0]    match_index;
		logic [ADDR_W-1:0]   hop_addr;
		logic [PORT_W-1:0]   out_port;
		logic [METRIC_W-1:0] metric;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   prefix;
		logic [ADDR_W-1:0]   mask;
		logic [ADDR_W-1:0]   gateway;
		logic [PORT_W-1:0]   port;
		logic [METRIC_W-1:0] metric;
	} entry_t;

	typedef struct packed {
		logic              slot_ok;
		logic              best_hit;
		logic [ADDR_W-1:0] best_mask;
	} cmp_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

@@ design/lpm_chan_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one payload per transfer
interface lpm_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/lpm_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ design/lpm_match.sv @@
`timescale 1ns / 1ps
// shared prefix compare unit: decides whether one slot beats the current best
module lpm_match (
	input  lpm_pkg::entry_t             entry,
	input  lpm_pkg::cmp_ctl_t           ctl,
	input  logic [lpm_pkg::ADDR_W-1:0]  address,
	output logic                        take
);
	import lpm_pkg::*;

	logic hit;
	logic longer;

	assign hit    = ctl.slot_ok && (((address ^ entry.prefix) & entry.mask) == '0);
	assign longer = !ctl.best_hit || (entry.mask > ctl.best_mask);
	assign take   = hit && longer;
endmodule

@@ design/longest_prefix_route_lookup.sv @@
`timescale 1ns / 1ps
// longest prefix route lookup: route memory, scan sequencer and result register
// A write transfer stores one route. A lookup walks the route memory one slot per
// cycle through a single prefix comparator, then passes the drain and finish steps,
// and the result is loaded in the finish step once the output register is free; the
// input is not ready during the walk. Since entry_index is five bits wide, the memory
// holds min(TABLE_DEPTH, 32) slots. Slot valid bits are flops cleared by reset, so no
// clearing pass is needed. The result waits in an output register, and the next item
// can be transferred while it waits.
module longest_prefix_route_lookup #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	lpm_chan_if.sink   req,
	lpm_chan_if.source rsp
);
	import lpm_pkg::*;

	localparam int SLOTS = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
	localparam int AW    = $clog2(SLOTS);

	state_t state_q, state_d;

	req_t   req_item;
	logic   accept;
	logic   acc_lookup;
	logic   req_ready;
	logic   rd_en;
	logic   load_rsp;
	logic   last_slot;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	entry_t        rd_entry;

	logic [AW-1:0]     cnt_q;
	logic [ADDR_W-1:0] addr_q;
	logic              pend_s1;
	logic [AW-1:0]     idx_s1;
	logic [SLOTS-1:0]  valid_q;

	logic          hit_q;
	logic [AW-1:0] best_idx_q;
	entry_t        best_q;

	cmp_ctl_t cmp_ctl;
	logic     take;

	rsp_t result;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign req_item   = req.data;
	assign accept     = req.valid && req_ready;
	assign acc_lookup = accept && (req_item.cmd == CMD_LOOKUP);
	assign last_slot  = (cnt_q == AW'(SLOTS - 1));

	// write path with port and metric clamping
	assign wr_en   = accept && (req_item.cmd == CMD_WRITE) &&
		(int'(req_item.entry_index) < SLOTS);
	assign wr_addr = req_item.entry_index[AW-1:0];

	always_comb begin
		wr_entry.prefix  = req_item.address;
		wr_entry.mask    = req_item.prefix_mask;
		wr_entry.gateway = req_item.gateway;
		if (int'(req_item.port) >= PORT_COUNT) begin
			wr_entry.port = PORT_W'(PORT_COUNT - 1);
		end else begin
			wr_entry.port = req_item.port;
		end
		if (req_item.route_metric > METRIC_INF) begin
			wr_entry.metric = METRIC_INF;
		end else begin
			wr_entry.metric = req_item.route_metric;
		end
	end

	lpm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_entry)
	);

	always_comb begin
		cmp_ctl.slot_ok   = valid_q[idx_s1];
		cmp_ctl.best_hit  = hit_q;
		cmp_ctl.best_mask = best_q.mask;
	end

	lpm_match u_match (
		.entry   (rd_entry),
		.ctl     (cmp_ctl),
		.address (addr_q),
		.take    (take)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_lookup) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_slot) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
				rd_en = 1'b0;
			end
			ST_FINISH: begin
				load_rsp = !rsp_valid_q || rsp.ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= req_item.entry_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (acc_lookup) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (acc_lookup) begin
				hit_q <= 1'b0;
			end else if (pend_s1 && take) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (acc_lookup) begin
			addr_q <= req_item.address;
		end
		if (pend_s1 && take) begin
			best_idx_q <= idx_s1;
			best_q     <= rd_entry;
		end
	end

	// result formation and output register
	always_comb begin
		if (hit_q) begin
			result.found       = 1'b1;
			result.match_index = IDX_W'(best_idx_q);
			result.hop_addr    = (best_q.gateway == '0) ? addr_q : best_q.gateway;
			result.out_port    = best_q.port;
			result.metric      = best_q.metric;
		end else begin
			result.found       = 1'b0;
			result.match_index = '0;
			result.hop_addr    = '0;
			result.out_port    = '0;
			result.metric      = METRIC_INF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= result;
		end
	end

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		acc_lookup |=> (state_q == ST_SCAN))
		else $error("lookup transfer did not start a scan");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside the finish step");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_item.cmd == CMD_WRITE) && !rsp_valid_q) |=> !rsp_valid_q)
		else $error("write transfer produced a result");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (int'(cnt_q) < SLOTS))
		else $error("scan counter beyond the table");
endmodule
